@@ sv/tfsq_pkg.sv @@
// ----------------------------------------------------------------------------
// tfsq_pkg: shared types and constants of the timestamp frame select queue
// Ring geometry, field widths, register indexes, status codes, FSM states
// and the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tfsq_pkg;

  // Ring geometry
  localparam int RING_DEPTH = 16;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);

  // Field widths
  localparam int TIME_W     = 48;
  localparam int HANDLE_W   = 32;
  localparam int CAP_W      = 5;
  localparam int TOL_W      = 20;
  localparam int DROP_W     = 4;
  localparam int OCC_W      = 5;
  localparam int STATUS_W   = 3;
  localparam int ENTRY_W    = TIME_W + HANDLE_W;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd1;

  // Register reset values
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic [TOL_W-1:0] TOL_RESET = 20'd40000;
  localparam int               CAP_MIN   = 2;

  localparam logic [DROP_W-1:0] DROP_MAX = '1;

  // Operation codes
  localparam logic OP_PUSH    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STS_PUSHED = 3'd0,
    STS_FULL   = 3'd1,
    STS_FRAME  = 3'd2,
    STS_EMPTY  = 3'd3,
    STS_WAIT   = 3'd4
  } result_status_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_FRONT,
    ST_WALK,
    ST_POP,
    ST_RESULT
  } ctrl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic           latch;       // capture the accepted word
    logic           push;        // store frame at tail
    logic           rd_front;    // read entry at read pointer
    logic           take_front;  // hold front entry, read the one after it
    logic           take_next;   // drop current, hold next, read the one after
    logic           pop;         // retire held entry
    logic           set_sts;     // record result status
    result_status_t sts;
    logic           load_out;    // move result into output register
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_push;
    logic full;
    logic empty;
    logic late_front;  // front time beyond target plus tolerance
    logic next_ok;     // next time at or below target
    logic gt1;         // more than one entry held
    logic gt2;         // more than two entries held
    logic slot_free;   // output register can take a result
  } dpath_sts_t;

endpackage

`default_nettype wire

@@ sv/tfsq_ram.sv @@
// ----------------------------------------------------------------------------
// tfsq_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tfsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

@@ sv/tfsq_ctrl.sv @@
// ----------------------------------------------------------------------------
// tfsq_ctrl: controller of the timestamp frame select queue
// Sequences push, request, the late-frame walk and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tfsq_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire tfsq_pkg::dpath_sts_t sts,
  output tfsq_pkg::ctrl_cmd_t      cmd
);

  tfsq_pkg::ctrl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tfsq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == tfsq_pkg::ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.sts   = tfsq_pkg::STS_PUSHED;
    unique case (state_r)
      tfsq_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = tfsq_pkg::ST_DISPATCH;
        end
      end
      tfsq_pkg::ST_DISPATCH: begin
        cmd.set_sts = 1'b1;
        if (sts.is_push) begin
          if (sts.full) begin
            cmd.sts = tfsq_pkg::STS_FULL;
          end else begin
            cmd.push = 1'b1;
            cmd.sts  = tfsq_pkg::STS_PUSHED;
          end
          state_nxt = tfsq_pkg::ST_RESULT;
        end else if (sts.empty) begin
          cmd.sts   = tfsq_pkg::STS_EMPTY;
          state_nxt = tfsq_pkg::ST_RESULT;
        end else begin
          cmd.set_sts  = 1'b0;
          cmd.rd_front = 1'b1;
          state_nxt    = tfsq_pkg::ST_FRONT;
        end
      end
      tfsq_pkg::ST_FRONT: begin
        if (sts.late_front) begin
          cmd.set_sts = 1'b1;
          cmd.sts     = tfsq_pkg::STS_WAIT;
          state_nxt   = tfsq_pkg::ST_RESULT;
        end else begin
          cmd.take_front = 1'b1;
          state_nxt      = sts.gt1 ? tfsq_pkg::ST_WALK : tfsq_pkg::ST_POP;
        end
      end
      tfsq_pkg::ST_WALK: begin
        // drop late frames one entry a cycle
        if (sts.next_ok) begin
          cmd.take_next = 1'b1;
          state_nxt     = sts.gt2 ? tfsq_pkg::ST_WALK : tfsq_pkg::ST_POP;
        end else begin
          state_nxt = tfsq_pkg::ST_POP;
        end
      end
      tfsq_pkg::ST_POP: begin
        cmd.pop     = 1'b1;
        cmd.set_sts = 1'b1;
        cmd.sts     = tfsq_pkg::STS_FRAME;
        state_nxt   = tfsq_pkg::ST_RESULT;
      end
      tfsq_pkg::ST_RESULT: begin
        if (sts.slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = tfsq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tfsq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/tfsq_dpath.sv @@
// ----------------------------------------------------------------------------
// tfsq_dpath: datapath of the timestamp frame select queue
// Frame RAM, ring pointers, configuration registers, walk registers and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tfsq_dpath (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire tfsq_pkg::ctrl_cmd_t                cmd,
  output tfsq_pkg::dpath_sts_t                    sts,
  input  wire logic                               in_operation,
  input  wire logic [tfsq_pkg::TIME_W-1:0]        in_frame_time,
  input  wire logic [tfsq_pkg::HANDLE_W-1:0]      in_frame_handle,
  input  wire logic [tfsq_pkg::TIME_W-1:0]        in_target_time,
  input  wire logic                               cfg_valid,
  input  wire logic [tfsq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tfsq_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [tfsq_pkg::STATUS_W-1:0]           out_status,
  output logic [tfsq_pkg::HANDLE_W-1:0]           out_handle,
  output logic [tfsq_pkg::TIME_W-1:0]             out_time,
  output logic [tfsq_pkg::DROP_W-1:0]             out_dropped_count,
  output logic [tfsq_pkg::OCC_W-1:0]              out_occupancy
);

  localparam int PTR_W    = tfsq_pkg::PTR_W;
  localparam int CNT_W    = tfsq_pkg::CNT_W;
  localparam int TIME_W   = tfsq_pkg::TIME_W;
  localparam int HANDLE_W = tfsq_pkg::HANDLE_W;

  // Step a ring pointer, wrapping at the active capacity
  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] n;
    n = CNT_W'(p) + CNT_W'(1);
    return (n >= cap) ? '0 : n[PTR_W-1:0];
  endfunction

  // Configuration and ring control
  logic [tfsq_pkg::CAP_W-1:0] cap_r;
  logic [tfsq_pkg::TOL_W-1:0] tol_r;
  logic [PTR_W-1:0]           rp_r, wp_r;
  logic [CNT_W-1:0]           count_r;
  logic [CNT_W-1:0]           cap_eff;

  // Latched word and walk state
  logic                         op_r;
  logic [TIME_W-1:0]            push_time_r;
  logic [HANDLE_W-1:0]          push_handle_r;
  logic [TIME_W-1:0]            target_r;
  logic [TIME_W-1:0]            limit_r;
  logic [PTR_W-1:0]             cur_ptr_r;
  logic [PTR_W-1:0]             rd_addr_r;
  logic [TIME_W-1:0]            cur_time_r;
  logic [HANDLE_W-1:0]          cur_handle_r;
  logic [tfsq_pkg::DROP_W-1:0]  dropped_r;
  tfsq_pkg::result_status_t     res_sts_r;

  // RAM ports
  logic                         ram_re;
  logic [PTR_W-1:0]             ram_raddr;
  logic [tfsq_pkg::ENTRY_W-1:0] ram_rdata;
  logic [TIME_W-1:0]            rd_time;
  logic [HANDLE_W-1:0]          rd_handle;
  logic [TIME_W:0]              limit_sum;
  logic                         is_frame;

  // Clamp capacity to the usable range
  always_comb begin
    logic [31:0] c;
    c = 32'(cap_r);
    if (c < 32'(tfsq_pkg::CAP_MIN)) begin
      cap_eff = CNT_W'(tfsq_pkg::CAP_MIN);
    end else if (c > 32'(tfsq_pkg::RING_DEPTH)) begin
      cap_eff = CNT_W'(tfsq_pkg::RING_DEPTH);
    end else begin
      cap_eff = CNT_W'(cap_r);
    end
  end

  // Frame store: time above handle
  tfsq_ram #(
    .WIDTH (tfsq_pkg::ENTRY_W),
    .DEPTH (tfsq_pkg::RING_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (wp_r),
    .wdata ({push_time_r, push_handle_r}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_time   = ram_rdata[tfsq_pkg::ENTRY_W-1:HANDLE_W];
  assign rd_handle = ram_rdata[HANDLE_W-1:0];

  // Pick the read address for front, first and following walk reads
  always_comb begin
    ram_re    = cmd.rd_front | cmd.take_front | cmd.take_next;
    ram_raddr = rp_r;
    priority if (cmd.take_front) begin
      ram_raddr = advance(rp_r, cap_eff);
    end else if (cmd.take_next) begin
      ram_raddr = advance(rd_addr_r, cap_eff);
    end
  end

  // Target plus tolerance with a carry bit, saturated when latched
  assign limit_sum = {1'b0, in_target_time} + (TIME_W + 1)'(tol_r);

  // Configuration registers and ring pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= tfsq_pkg::CAP_RESET;
      tol_r   <= tfsq_pkg::TOL_RESET;
      rp_r    <= '0;
      wp_r    <= '0;
      count_r <= '0;
    end else if (cfg_valid && cfg_index == tfsq_pkg::CFG_CAPACITY) begin
      // a capacity write restarts the ring
      cap_r   <= cfg_data[tfsq_pkg::CAP_W-1:0];
      rp_r    <= '0;
      wp_r    <= '0;
      count_r <= '0;
    end else begin
      if (cfg_valid && cfg_index == tfsq_pkg::CFG_TOLERANCE) begin
        tol_r <= cfg_data[tfsq_pkg::TOL_W-1:0];
      end
      if (cmd.push) begin
        wp_r    <= advance(wp_r, cap_eff);
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.take_next) begin
        count_r <= count_r - CNT_W'(1);
      end
      if (cmd.pop) begin
        rp_r    <= advance(cur_ptr_r, cap_eff);
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  // Latch the word and run the walk
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r          <= in_operation;
      push_time_r   <= in_frame_time;
      push_handle_r <= in_frame_handle;
      target_r      <= in_target_time;
      limit_r       <= limit_sum[TIME_W] ? '1 : limit_sum[TIME_W-1:0];
      dropped_r     <= '0;
    end
    if (ram_re) begin
      rd_addr_r <= ram_raddr;
    end
    if (cmd.take_front) begin
      cur_ptr_r    <= rp_r;
      cur_time_r   <= rd_time;
      cur_handle_r <= rd_handle;
    end
    if (cmd.take_next) begin
      cur_ptr_r    <= rd_addr_r;
      cur_time_r   <= rd_time;
      cur_handle_r <= rd_handle;
      if (dropped_r != tfsq_pkg::DROP_MAX) begin
        dropped_r <= dropped_r + tfsq_pkg::DROP_W'(1);
      end
    end
    if (cmd.set_sts) begin
      res_sts_r <= cmd.sts;
    end
  end

  // Status toward the controller
  always_comb begin
    sts.is_push    = (op_r == tfsq_pkg::OP_PUSH);
    sts.full       = (count_r >= cap_eff);
    sts.empty      = (count_r == '0);
    sts.late_front = (rd_time > limit_r);
    sts.next_ok    = (rd_time <= target_r);
    sts.gt1        = (count_r > CNT_W'(1));
    sts.gt2        = (count_r > CNT_W'(2));
    sts.slot_free  = !out_valid || out_ready;
  end

  assign is_frame = (res_sts_r == tfsq_pkg::STS_FRAME);

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status        <= res_sts_r;
      out_handle        <= is_frame ? cur_handle_r : '0;
      out_time          <= is_frame ? cur_time_r : '0;
      out_dropped_count <= is_frame ? dropped_r : '0;
      out_occupancy     <= tfsq_pkg::OCC_W'(count_r);
    end
  end

endmodule

`default_nettype wire

@@ sv/timestamp_frame_select_queue.sv @@
// ----------------------------------------------------------------------------
// timestamp_frame_select_queue: video frame ring with late-frame drop
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// Accepts one word at a time: a push stores a frame (timestamp and handle)
// at the tail, or a request picks the frame to show for a target time,
// dropping late frames on the way. A push, a full push or an empty request
// goes from the accepting state through dispatch to the result state; a
// request that waits also reads the front frame, and a request that returns
// a frame also takes the front, walks one step per dropped frame and one
// more step when the walk stops at a frame still ahead of the target, and
// pops, because the walk reads the frame RAM's single read port one entry a
// cycle. The next word can be taken once the result enters the output
// register, which holds it until the consumer takes it. Configuration
// writes are always ready; a capacity write empties the ring.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamp_frame_select_queue (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_operation,
  input  wire logic [tfsq_pkg::TIME_W-1:0]     in_frame_time,
  input  wire logic [tfsq_pkg::HANDLE_W-1:0]   in_frame_handle,
  input  wire logic [tfsq_pkg::TIME_W-1:0]     in_target_time,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [tfsq_pkg::STATUS_W-1:0]        out_status,
  output logic [tfsq_pkg::HANDLE_W-1:0]        out_handle,
  output logic [tfsq_pkg::TIME_W-1:0]          out_time,
  output logic [tfsq_pkg::DROP_W-1:0]          out_dropped_count,
  output logic [tfsq_pkg::OCC_W-1:0]           out_occupancy,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [tfsq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tfsq_pkg::CFG_DATA_W-1:0] cfg_data
);

  tfsq_pkg::ctrl_cmd_t  cmd;
  tfsq_pkg::dpath_sts_t sts;

  // Writes must arrive only while idle (not enforced); take them at once
  assign cfg_ready = 1'b1;

  tfsq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tfsq_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_operation      (in_operation),
    .in_frame_time     (in_frame_time),
    .in_frame_handle   (in_frame_handle),
    .in_target_time    (in_target_time),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_handle        (out_handle),
    .out_time          (out_time),
    .out_dropped_count (out_dropped_count),
    .out_occupancy     (out_occupancy)
  );

endmodule

`default_nettype wire

@@ sv/tfsq_checker.sv @@
// ----------------------------------------------------------------------------
// tfsq_checker: port-level checks of the timestamp frame select queue
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tfsq_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [tfsq_pkg::STATUS_W-1:0]   out_status,
  input wire logic [tfsq_pkg::HANDLE_W-1:0]   out_handle,
  input wire logic [tfsq_pkg::TIME_W-1:0]     out_time,
  input wire logic [tfsq_pkg::DROP_W-1:0]     out_dropped_count,
  input wire logic [tfsq_pkg::OCC_W-1:0]      out_occupancy
);

  // Hold valid, status, handle, time and occupancy of a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_handle) && $stable(out_time) && $stable(out_occupancy))
    else $error("result word changed while stalled");

  // Zero frame fields unless a frame is returned
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != tfsq_pkg::STS_FRAME |->
      out_handle == '0 && out_time == '0 && out_dropped_count == '0)
    else $error("frame fields set on a non-frame result");

  // Empty answer leaves nothing held
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == tfsq_pkg::STS_EMPTY |-> out_occupancy == '0)
    else $error("empty result with entries held");

  // Full push means at least the minimum capacity is held
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == tfsq_pkg::STS_FULL |->
      out_occupancy >= tfsq_pkg::OCC_W'(tfsq_pkg::CAP_MIN))
    else $error("full result below minimum capacity");

  // Occupancy never exceeds the ring
  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_occupancy) <= 32'(tfsq_pkg::RING_DEPTH))
    else $error("occupancy beyond ring depth");

endmodule

bind timestamp_frame_select_queue tfsq_checker u_tfsq_checker (.*);

`default_nettype wire
